### rtl/dtq_pkg.sv
package dtq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned TimeW = 48;
  localparam int unsigned DelayW = 32;
  localparam int unsigned HandleW = 32;

  typedef enum logic [1:0] {
    FN_QUERY   = 2'd0,
    FN_ENQUEUE = 2'd1,
    FN_DEQUEUE = 2'd2,
    FN_REMOVE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NONE_DUE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [TimeW-1:0]   deadline;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef struct packed {
    cell_op_t           op;
    logic [TimeW-1:0]   deadline;
    logic [HandleW-1:0] handle;
  } cell_cmd_t;

endpackage

### rtl/dtq_in_if.sv
interface dtq_in_if;
  import dtq_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [TimeW-1:0]   now_us;
  logic [DelayW-1:0]  delay_us;
  logic [HandleW-1:0] item_handle;

  modport source (output valid, func, now_us, delay_us, item_handle, input ready);
  modport sink   (input valid, func, now_us, delay_us, item_handle, output ready);
endinterface

### rtl/dtq_out_if.sv
interface dtq_out_if;
  import dtq_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [HandleW-1:0] out_handle;
  logic               queue_empty;
  logic               head_due;
  logic [HandleW-1:0] head_handle;
  logic [TimeW-1:0]   time_to_next;

  modport source (output valid, status, out_handle, queue_empty, head_due, head_handle,
                  time_to_next, input ready);
  modport sink   (input valid, status, out_handle, queue_empty, head_due, head_handle,
                  time_to_next, output ready);
endinterface

### rtl/dtq_cell.sv
module dtq_cell
  import dtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  input  logic      left_ins,
  input  logic      left_hit,
  output entry_t    entry,
  output logic      ins,
  output logic      hit
);

  entry_t entry_r;
  entry_t entry_nxt;
  entry_t new_entry;

  assign new_entry = '{valid: 1'b1, deadline: cmd.deadline, handle: cmd.handle};

  // insertion point is at or before this cell
  assign ins = !entry_r.valid || (entry_r.deadline > cmd.deadline);
  // first handle match is at or before this cell
  assign hit = left_hit || (entry_r.valid && (entry_r.handle == cmd.handle));

  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (ins) begin
          entry_nxt = left_ins ? left_entry : new_entry;
        end
      end
      CELL_POP: entry_nxt = right_entry;
      CELL_REMOVE: begin
        if (hit) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;

endmodule

### rtl/deadline_timer_queue.sv
// Sorted timer queue of DEPTH entries, each a 48-bit absolute deadline in
// microseconds and a 32-bit handle, kept in a row of cells in deadline order.
// in_ch carries one operation per transfer: query, enqueue (now_us + delay_us,
// saturated), dequeue of the head if due, or remove of the first matching
// handle. out_ch returns exactly one result per operation: its status, the
// dequeued handle, and the head of the queue after the operation (empty flag,
// due flag, head handle, time to the next deadline clamped at zero).
// An input transfer updates the cells, and the result then passes through the
// output register to out_ch. Throughput is one operation per cycle while out_ch
// is not stalled: every cell compares against the operation in parallel and moves
// one step toward its neighbor, and the result register reads the head cell after the update.
// Reset empties the queue at once and clears both handshakes; no fill pass.
// When the receiver stalls, one finished result waits in the output register
// and one more operation may be applied; after that in_ch.ready drops until
// out_ch is drained.
module deadline_timer_queue
  import dtq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  dtq_in_if.sink   in_ch,
  dtq_out_if.source out_ch
);

  entry_t    cells   [DEPTH+1];
  logic      ins_c   [DEPTH+1];
  logic      hit_c   [DEPTH+1];
  cell_cmd_t cmd;

  logic [TimeW:0]     sum;
  logic [TimeW-1:0]   new_deadline;
  logic               in_xfer;
  logic               load_out;
  logic               head_due_now;
  logic               full;

  logic               pend_r;
  status_t            status_r;
  logic [HandleW-1:0] taken_r;
  logic [TimeW-1:0]   now_r;
  status_t            status_nxt;
  logic [HandleW-1:0] taken_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [HandleW-1:0] out_handle_r;
  logic               out_empty_r;
  logic               out_due_r;
  logic [HandleW-1:0] out_head_r;
  logic [TimeW-1:0]   out_ttn_r;

  assign cells[DEPTH] = '0;
  assign ins_c[0] = 1'b0;
  assign hit_c[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dtq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  ((i == 0) ? cells[DEPTH] : cells[(i == 0) ? 0 : i-1]),
      .right_entry (cells[i+1]),
      .left_ins    (ins_c[i]),
      .left_hit    (hit_c[i]),
      .entry       (cells[i]),
      .ins         (ins_c[i+1]),
      .hit         (hit_c[i+1])
    );
  end

  // saturate the deadline at the largest time value
  assign sum = {1'b0, in_ch.now_us} + {{(TimeW+1-DelayW){1'b0}}, in_ch.delay_us};
  assign new_deadline = sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];

  assign full = cells[DEPTH-1].valid;
  assign head_due_now = cells[0].valid && (cells[0].deadline <= in_ch.now_us);

  assign load_out = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || load_out;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.op = CELL_HOLD;
    cmd.deadline = new_deadline;
    cmd.handle = in_ch.item_handle;
    status_nxt = ST_OK;
    taken_nxt = '0;
    case (func_t'(in_ch.func))
      FN_ENQUEUE: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op = CELL_INSERT;
        end
      end
      FN_DEQUEUE: begin
        if (head_due_now) begin
          cmd.op = CELL_POP;
          taken_nxt = cells[0].handle;
        end else begin
          status_nxt = ST_NONE_DUE;
        end
      end
      FN_REMOVE: begin
        cmd.op = CELL_REMOVE;
        if (!hit_c[DEPTH]) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: cmd.op = CELL_HOLD;
    endcase
    if (!in_xfer) begin
      cmd.op = CELL_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status_nxt;
      taken_r <= taken_nxt;
      now_r <= in_ch.now_us;
    end
    // the head cell already holds the state after the pending operation
    if (load_out) begin
      out_status_r <= status_r;
      out_handle_r <= taken_r;
      out_empty_r <= !cells[0].valid;
      out_due_r <= cells[0].valid && (cells[0].deadline <= now_r);
      out_head_r <= cells[0].valid ? cells[0].handle : '0;
      out_ttn_r <= (cells[0].valid && (cells[0].deadline > now_r))
                   ? (cells[0].deadline - now_r) : '0;
    end
    if (!rst_n) begin
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (load_out) begin
        pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.out_handle = out_handle_r;
  assign out_ch.queue_empty = out_empty_r;
  assign out_ch.head_due = out_due_r;
  assign out_ch.head_handle = out_head_r;
  assign out_ch.time_to_next = out_ttn_r;

endmodule

### sim/dtq_result_checker.sv
module dtq_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  dtq_in_if           in_mon,
  dtq_out_if          out_mon,
  output int unsigned mismatches,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import dtq_pkg::*;

  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef struct packed {
    status_t            status;
    logic [HandleW-1:0] taken;
    logic               empty;
    logic               due;
    logic [HandleW-1:0] head;
    logic [TimeW-1:0]   wait_us;
  } timer_result_t;

  // sorted copy of the queue contents
  logic [TimeW-1:0]   deadlines [DEPTH];
  logic [HandleW-1:0] handles   [DEPTH];
  int unsigned        fill;

  timer_result_t      pending_results [$];
  int unsigned        fail_tally;

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned k = pos; k + 1 < fill; k++) begin
      deadlines[k] = deadlines[k + 1];
      handles[k]   = handles[k + 1];
    end
    fill--;
  endfunction

  function automatic timer_result_t timer_queue_step(func_t op, logic [TimeW-1:0] now,
                                                     logic [DelayW-1:0] delay,
                                                     logic [HandleW-1:0] hnd);
    timer_result_t    r;
    logic [TimeW:0]   sum;
    logic [TimeW-1:0] dl;
    int unsigned      pos;
    bit               found;
    r        = '0;
    r.status = ST_OK;
    case (op)
      FN_ENQUEUE: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          sum = {1'b0, now} + {{(TimeW + 1 - DelayW){1'b0}}, delay};
          dl  = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
          pos = 0;
          // equal deadlines keep arrival order
          while (pos < fill && deadlines[pos] <= dl) pos++;
          for (int unsigned k = fill; k > pos; k--) begin
            deadlines[k] = deadlines[k - 1];
            handles[k]   = handles[k - 1];
          end
          deadlines[pos] = dl;
          handles[pos]   = hnd;
          fill++;
        end
      end
      FN_DEQUEUE: begin
        if (fill == 0 || deadlines[0] > now) begin
          r.status = ST_NONE_DUE;
        end else begin
          r.taken = handles[0];
          drop_entry(0);
        end
      end
      FN_REMOVE: begin
        found = 1'b0;
        for (int unsigned k = 0; k < fill && !found; k++) begin
          if (handles[k] == hnd) begin
            drop_entry(k);
            found = 1'b1;
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    if (fill == 0) begin
      r.empty = 1'b1;
    end else begin
      r.due     = deadlines[0] <= now;
      r.head    = handles[0];
      r.wait_us = (deadlines[0] > now) ? deadlines[0] - now : '0;
    end
    return r;
  endfunction

  function automatic int unsigned field_diff(string name, logic [63:0] want,
                                             logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    if (!rst_n) begin
      fill = 0;
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no operation waiting");
          fail_tally++;
        end else begin
          want = pending_results.pop_front();
          fail_tally += field_diff("status", want.status, out_mon.status);
          fail_tally += field_diff("out_handle", want.taken, out_mon.out_handle);
          fail_tally += field_diff("queue_empty", want.empty, out_mon.queue_empty);
          fail_tally += field_diff("head_due", want.due, out_mon.head_due);
          fail_tally += field_diff("head_handle", want.head, out_mon.head_handle);
          fail_tally += field_diff("time_to_next", want.wait_us, out_mon.time_to_next);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(timer_queue_step(func_t'(in_mon.func), in_mon.now_us,
                                                   in_mon.delay_us, in_mon.item_handle));
      end
    end
    mismatches  <= fail_tally;
    outstanding <= pending_results.size();
  end

endmodule

### sim/tb_deadline_timer_queue.sv
module tb_deadline_timer_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import dtq_pkg::*;

  localparam int unsigned RandomOps  = 850;
  localparam int unsigned CalmTail   = 120;
  localparam int unsigned CycleLimit = 200000;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [HandleW-1:0] HandleA = 32'hA5A5_0001;
  localparam logic [HandleW-1:0] HandleB = 32'h5A5A_0002;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bit                 calm = 1'b0;
  int unsigned        gap_odds = 4;
  int unsigned        mismatches;
  int unsigned        outstanding;
  logic [TimeW-1:0]   clock_us;
  logic [HandleW-1:0] recent_handles [$];

  dtq_in_if  in_ch ();
  dtq_out_if out_ch ();

  deadline_timer_queue i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dtq_result_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [TimeW-1:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [DelayW-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      2:       return '1;
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic logic [HandleW-1:0] pick_handle();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 7);
      default: begin
        if (recent_handles.size() == 0) return $urandom;
        return recent_handles[$urandom_range(0, recent_handles.size() - 1)];
      end
    endcase
  endfunction

  function automatic void advance_clock();
    case ($urandom_range(0, 19))
      0:       clock_us = rand_time();
      1:       clock_us = TimeMax - $urandom_range(0, 500);
      2:       clock_us += $urandom_range(0, 100000);
      default: clock_us += $urandom_range(0, 60);
    endcase
  endfunction

  task automatic send_op(func_t op, logic [TimeW-1:0] now, logic [DelayW-1:0] delay,
                         logic [HandleW-1:0] hnd);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= op;
    in_ch.now_us      <= now;
    in_ch.delay_us    <= delay;
    in_ch.item_handle <= hnd;
    if (op == FN_ENQUEUE) begin
      recent_handles.push_back(hnd);
      if (recent_handles.size() > 24) void'(recent_handles.pop_front());
    end
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("FAIL deadline_timer_queue");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int unsigned issued;
    int unsigned mode;
    int unsigned len;
    func_t       op;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= FN_QUERY;
    in_ch.now_us      <= '0;
    in_ch.delay_us    <= '0;
    in_ch.item_handle <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue: query, dequeue with nothing due, remove with no match
    send_op(FN_QUERY, '0, '0, '0);
    send_op(FN_DEQUEUE, '0, '0, '0);
    send_op(FN_REMOVE, 48'd5, '0, HandleA);
    send_op(FN_ENQUEUE, '0, '0, '0);
    // saturating deadline
    send_op(FN_ENQUEUE, TimeMax, '1, '1);
    // equal deadlines, then a duplicate handle ahead of them
    send_op(FN_ENQUEUE, 48'd100, 32'd50, HandleA);
    send_op(FN_ENQUEUE, 48'd100, 32'd50, HandleB);
    send_op(FN_ENQUEUE, 48'd100, 32'd10, HandleA);
    for (int i = 0; i < 11; i++) send_op(FN_ENQUEUE, 48'd200, $urandom_range(0, 1000), $urandom);
    send_op(FN_ENQUEUE, 48'd300, 32'd5, 32'hDEAD_BEEF);
    send_op(FN_REMOVE, 48'd120, '0, HandleA);
    send_op(FN_REMOVE, 48'd120, '0, 32'h1234_5678);
    send_op(FN_DEQUEUE, '0, '0, '0);
    send_op(FN_DEQUEUE, 48'd100, '0, '0);
    send_op(FN_QUERY, TimeMax, '0, '0);
    send_op(FN_DEQUEUE, 48'd150, '0, '0);
    drain_results();

    clock_us = 48'd1000;
    issued   = 0;
    while (issued < RandomOps) begin
      calm     = issued + CalmTail >= RandomOps;
      gap_odds = calm ? 0 : (($urandom_range(0, 2) == 0) ? 0 : 4);
      if (!calm && $urandom_range(0, 9) == 0) drain_results();
      mode = $urandom_range(0, 4);
      len  = $urandom_range(8, 40);
      repeat (len) begin
        advance_clock();
        case (mode)
          0: begin
            op = ($urandom_range(0, 4) == 0) ? FN_QUERY : FN_ENQUEUE;
            send_op(op, clock_us, pick_delay(), pick_handle());
          end
          1: begin
            clock_us += $urandom_range(0, 200);
            op = ($urandom_range(0, 5) == 0) ? FN_ENQUEUE : FN_DEQUEUE;
            send_op(op, clock_us, pick_delay(), pick_handle());
          end
          2: begin
            op = ($urandom_range(0, 4) < 3) ? FN_REMOVE : FN_ENQUEUE;
            send_op(op, clock_us, pick_delay(), pick_handle());
          end
          3: begin
            send_op(func_t'($urandom_range(0, 3)), clock_us, pick_delay(), pick_handle());
          end
          default: begin
            send_op(func_t'($urandom_range(0, 3)), rand_time(), $urandom, $urandom);
          end
        endcase
        issued++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS deadline_timer_queue");
    end else begin
      $display("FAIL deadline_timer_queue");
    end
    $finish;
  end

endmodule
